// ===== src/sorted_key_find_or_insert_assert.svh =====
// ----------------------------------------------------------------------------
// sorted_key_find_or_insert assertion macros
// shared property shapes for the checker, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_FIND_OR_INSERT_ASSERT_SVH
`define SORTED_KEY_FIND_OR_INSERT_ASSERT_SVH

// same-cycle implication
`define SKFI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SKFI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/skfi_pkg.sv =====
// ----------------------------------------------------------------------------
// skfi_pkg
// shared constants and types of the sorted key find-or-insert block
// ----------------------------------------------------------------------------
package skfi_pkg;

  localparam int CAPACITY = 64;
  localparam int DOC_W    = 64;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 6;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  // strobes from the sequencer to the cell row
  typedef struct packed {
    logic acc;  // word taken on the input side
    logic cmp;  // cells latch their compare flags
    logic upd;  // cells shift/insert, result registered
  } ctrl_t;

endpackage

// ===== src/sorted_key_find_or_insert.sv =====
// ----------------------------------------------------------------------------
// sorted_key_find_or_insert
// sorted key table with lookup or in-order insert, built as a row of cells
// ----------------------------------------------------------------------------
// usage
// - input channel: doc_id_i with in_valid_i / in_stall_o; a word is taken at
//   a clock edge with in_valid_i high and in_stall_o low
// - the key is doc_id_i[63:32]; a stored key returns its handle, a new key is
//   inserted in sorted order and gets handle = entries held before it
//   (is_new_o set); with the table full, table_full_o is set and handle is 0
// - output channel: child_handle_o, is_new_o, table_full_o with
//   out_valid_o / out_stall_i; one result word per input word
// - timing: a word passes the accept, compare and update steps in order; the
//   result is registered at the update step, and no new word is taken until
//   the word before has finished the compare/update pass of the cell row
// - out_stall_i holds the result register and the update step; the next
//   word may be accepted and compared meanwhile, then the input stalls
//   until the waiting result word leaves
// - reset empties the table (entry count to zero) and restarts the sequencer's accept/compare/update cycle
// ----------------------------------------------------------------------------
module sorted_key_find_or_insert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [skfi_pkg::DOC_W-1:0]    doc_id_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  output logic [skfi_pkg::HANDLE_W-1:0] child_handle_o,
  output logic                          is_new_o,
  output logic                          table_full_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i
);
  import skfi_pkg::*;

  ctrl_t ctrl;

  // search key, captured on accept
  logic [KEY_W-1:0] key_q;

  // entry count; slots below it hold valid keys
  logic [CNT_W-1:0] count_q, count_d;

  // cell row taps
  logic [KEY_W-1:0]    cell_key    [CAPACITY];
  logic [HANDLE_W-1:0] cell_handle [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;

  logic                found;
  logic [HANDLE_W-1:0] found_handle;
  logic                full;
  logic                ins;
  logic [HANDLE_W-1:0] new_handle;

  // result register
  logic [HANDLE_W-1:0] handle_q;
  logic                is_new_q;
  logic                full_q;

  skfi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .ctrl_o      (ctrl)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl.acc) begin
      key_q <= doc_id_i[DOC_W-1 -: KEY_W];
    end
  end

  assign full       = (count_q == CNT_W'(CAPACITY));
  assign new_handle = HANDLE_W'(count_q);
  assign ins        = !found && !full;

  // the row: cell 0 sees a virtual left neighbor that is always below the key
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                prev_lt;
    logic [KEY_W-1:0]    prev_key;
    logic [HANDLE_W-1:0] prev_handle;

    if (i == 0) begin : g_head
      assign prev_lt     = 1'b1;
      assign prev_key    = '0;
      assign prev_handle = '0;
    end else begin : g_body
      assign prev_lt     = cell_lt[i-1];
      assign prev_key    = cell_key[i-1];
      assign prev_handle = cell_handle[i-1];
    end

    skfi_cell u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .ins_i         (ins),
      .valid_i       (CNT_W'(i) < count_q),
      .key_i         (key_q),
      .new_handle_i  (new_handle),
      .prev_lt_i     (prev_lt),
      .prev_key_i    (prev_key),
      .prev_handle_i (prev_handle),
      .key_o         (cell_key[i]),
      .handle_o      (cell_handle[i]),
      .lt_o          (cell_lt[i]),
      .eq_o          (cell_eq[i])
    );
  end

  // keys are unique, so at most one cell matches; or the masked handles
  always_comb begin
    found        = |cell_eq;
    found_handle = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      found_handle = found_handle | (cell_handle[i] & {HANDLE_W{cell_eq[i]}});
    end
  end

  always_comb begin
    count_d = count_q;
    if (ctrl.upd && ins) begin
      count_d = count_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.upd) begin
      if (found) begin
        handle_q <= found_handle;
      end else if (full) begin
        handle_q <= '0;
      end else begin
        handle_q <= new_handle;
      end
      is_new_q <= ins;
      full_q   <= !found && full;
    end
  end

  assign child_handle_o = handle_q;
  assign is_new_o       = is_new_q;
  assign table_full_o   = full_q;

endmodule

// ===== src/skfi_cell.sv =====
// ----------------------------------------------------------------------------
// skfi_cell
// one table slot: key and handle, compares against the search key; takes the
// new entry when an insert lands on it, its left neighbor's when right of it
// ----------------------------------------------------------------------------
module skfi_cell (
  input  logic                          clk_i,
  input  skfi_pkg::ctrl_t               ctrl_i,
  input  logic                          ins_i,
  input  logic                          valid_i,
  input  logic [skfi_pkg::KEY_W-1:0]    key_i,
  input  logic [skfi_pkg::HANDLE_W-1:0] new_handle_i,
  input  logic                          prev_lt_i,
  input  logic [skfi_pkg::KEY_W-1:0]    prev_key_i,
  input  logic [skfi_pkg::HANDLE_W-1:0] prev_handle_i,
  output logic [skfi_pkg::KEY_W-1:0]    key_o,
  output logic [skfi_pkg::HANDLE_W-1:0] handle_o,
  output logic                          lt_o,
  output logic                          eq_o
);
  import skfi_pkg::*;

  logic [KEY_W-1:0]    key_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                lt_q;
  logic                eq_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.cmp) begin
      lt_q <= valid_i && (key_q < key_i);
      eq_q <= valid_i && (key_q == key_i);
    end
  end

  // slot left of the insert point stays, the insert point takes the new
  // entry, everything right of it moves one slot up
  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd && ins_i && !lt_q) begin
      if (prev_lt_i) begin
        key_q    <= key_i;
        handle_q <= new_handle_i;
      end else begin
        key_q    <= prev_key_i;
        handle_q <= prev_handle_i;
      end
    end
  end

  assign key_o    = key_q;
  assign handle_o = handle_q;
  assign lt_o     = lt_q;
  assign eq_o     = eq_q;

endmodule

// ===== src/skfi_ctrl.sv =====
// ----------------------------------------------------------------------------
// skfi_ctrl
// sequencer: accept, compare, update; owns the output valid register
// ----------------------------------------------------------------------------
module skfi_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            out_stall_i,
  output logic            in_stall_o,
  output logic            out_valid_o,
  output skfi_pkg::ctrl_t ctrl_o
);
  import skfi_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_CMP;
      ST_CMP:  state_d = ST_UPD;
      ST_UPD:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    ctrl_o.acc = (state_q == ST_IDLE) && in_valid_i;
    ctrl_o.cmp = (state_q == ST_CMP);
    ctrl_o.upd = (state_q == ST_UPD) && out_free;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.upd) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/skfi_checker.sv =====
// ----------------------------------------------------------------------------
// skfi_sva
// port-level checks of the sorted key find-or-insert block, bound to the top
// ----------------------------------------------------------------------------
`include "sorted_key_find_or_insert_assert.svh"

module skfi_sva (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic [skfi_pkg::HANDLE_W-1:0] child_handle_o,
  input logic                          is_new_o,
  input logic                          table_full_o,
  input logic                          out_valid_o,
  input logic                          out_stall_i
);
  import skfi_pkg::*;

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // a new insert and a full table never come together
  `SKFI_ASSERT_SAME(a_new_not_full, out_valid_o, !(is_new_o && table_full_o), "new and full both set")

  // a full-table result carries handle zero
  `SKFI_ASSERT_SAME(a_full_zero, out_valid_o && table_full_o, child_handle_o == '0, "full with nonzero handle")

  // one word at a time: after an accept the input side is busy
  `SKFI_ASSERT_NEXT(a_busy_after_acc, in_acc, in_stall_o, "input taken back to back")

  // a stalled result word holds
  `SKFI_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(child_handle_o) && $stable(is_new_o) && $stable(table_full_o), "stalled result changed")

endmodule

bind sorted_key_find_or_insert skfi_sva u_skfi_sva (.*);

// ===== test/skfi_checker.sv =====
// ----------------------------------------------------------------------------
// skfi_checker
// watches both channels of the sorted key find-or-insert block, keeps its own
// sorted key table and checks every result word against the oldest prediction
// ----------------------------------------------------------------------------
module skfi_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [skfi_pkg::DOC_W-1:0]    doc_id_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_o,
  input  logic [skfi_pkg::HANDLE_W-1:0] child_handle_o,
  input  logic                          is_new_o,
  input  logic                          table_full_o,
  input  logic                          out_valid_o,
  input  logic                          out_stall_i,
  output int                            fail_count,
  output int                            pending,
  output int                            n_inserted,
  output int                            n_hit,
  output int                            n_refused
);

  timeunit 1ns;
  timeprecision 1ps;

  import skfi_pkg::*;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic                is_new;
    logic                full;
  } lookup_res_t;

  typedef struct packed {
    logic [DOC_W-1:0] doc;
    lookup_res_t      res;
  } awaited_word_t;

  awaited_word_t expected_words[$];

  // shadow table, ascending keys
  logic [KEY_W-1:0]    key_tab[CAPACITY];
  logic [HANDLE_W-1:0] handle_tab[CAPACITY];
  int                  held;

  function automatic lookup_res_t predict_lookup(input logic [DOC_W-1:0] doc);
    logic [KEY_W-1:0] key;
    int               pos;
    lookup_res_t      r;
    key = doc[DOC_W-1:DOC_W-KEY_W];
    pos = 0;
    while (pos < held && key_tab[pos] < key) pos++;
    if (pos < held && key_tab[pos] == key) begin
      r.handle = handle_tab[pos];
      r.is_new = 1'b0;
      r.full   = 1'b0;
    end else if (held >= CAPACITY) begin
      r.handle = '0;
      r.is_new = 1'b0;
      r.full   = 1'b1;
    end else begin
      // handle is the entry count before the insert, wrapped to the handle width
      r.handle = HANDLE_W'(held);
      r.is_new = 1'b1;
      r.full   = 1'b0;
      for (int j = held; j > pos; j--) begin
        key_tab[j]    = key_tab[j-1];
        handle_tab[j] = handle_tab[j-1];
      end
      key_tab[pos]    = key;
      handle_tab[pos] = r.handle;
      held++;
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    awaited_word_t want;
    lookup_res_t   got;
    lookup_res_t   pred;
    if (!rst_ni) begin
      held       = 0;
      fail_count = 0;
      pending    = 0;
      n_inserted = 0;
      n_hit      = 0;
      n_refused  = 0;
      expected_words.delete();
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = '{handle: child_handle_o, is_new: is_new_o, full: table_full_o};
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_MAX)
            $display("%t: result word with nothing awaited: handle=%0d new=%b full=%b",
                     $realtime, got.handle, got.is_new, got.full);
        end else begin
          want = expected_words.pop_front();
          if (got.handle !== want.res.handle || got.is_new !== want.res.is_new ||
              got.full !== want.res.full) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
              $display("%t: doc %h: expected handle=%0d new=%b full=%b, got handle=%0d new=%b full=%b",
                       $realtime, want.doc, want.res.handle, want.res.is_new, want.res.full,
                       got.handle, got.is_new, got.full);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        pred = predict_lookup(doc_id_i);
        expected_words.insert(expected_words.size(), '{doc: doc_id_i, res: pred});
        if (pred.full) n_refused++;
        else if (pred.is_new) n_inserted++;
        else n_hit++;
      end
      pending = expected_words.size();
    end
  end

endmodule

// ===== test/tb_sorted_key_find_or_insert.sv =====
// ----------------------------------------------------------------------------
// tb_sorted_key_find_or_insert
// drives doc ids into the sorted key table: a directed opener around the key
// extremes, then random words that fill the table, hit stored keys and get
// refused once it is full; random idle bursts on both channels, one long
// output hold-off, and a quiet tail; checking is done by skfi_checker
// ----------------------------------------------------------------------------
module tb_sorted_key_find_or_insert;

  timeunit 1ns;
  timeprecision 1ps;

  import skfi_pkg::*;

  localparam int RANDOM_WORDS   = 1030;
  localparam int CALM_WORDS     = 100;   // last words sent with no idling at all
  localparam int HOLD_AT_WORD   = 500;   // random word index that starts the long hold-off
  localparam int LONG_HOLD      = 80;    // cycles the output is held off in one stretch
  localparam int DRAIN_CYCLES   = 16;    // quiet cycles waited after the last result
  localparam int WATCHDOG_LIMIT = 1000;  // far above the long hold-off plus a burst

  // dut ports
  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic [DOC_W-1:0]    doc_id_i;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [HANDLE_W-1:0] child_handle_o;
  logic                is_new_o;
  logic                table_full_o;
  logic                out_valid_o;
  logic                out_stall_i;

  // checker outputs
  int fail_count;
  int pending;
  int n_inserted;
  int n_hit;
  int n_refused;

  // stimulus controls shared with the output side
  int tx_gap_pct;
  int rx_stall_pct;
  bit calm_tail;
  bit long_hold_req;
  int holds_done;
  int words_sent;
  int stuck_cycles;

  // keys believed to be stored; only grows while the table has room, so
  // picking from it mostly gives hits
  logic [KEY_W-1:0] key_pool[$];
  bit               key_seen[logic [KEY_W-1:0]];

  sorted_key_find_or_insert DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .doc_id_i       (doc_id_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .child_handle_o (child_handle_o),
    .is_new_o       (is_new_o),
    .table_full_o   (table_full_o),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i)
  );

  skfi_checker u_checker (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // idle rate for one phase; zero gives stretches with no idling
  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 10;
      default: return 35;
    endcase
  endfunction

  function automatic logic [KEY_W-1:0] pick_known_key();
    return key_pool[$urandom_range(0, key_pool.size() - 1)];
  endfunction

  // mostly absent keys: fully random, a neighbor of a stored key (tests the
  // compare at the boundary), or something near either end of the key range
  function automatic logic [KEY_W-1:0] pick_fresh_key();
    logic [KEY_W-1:0] base;
    case ($urandom_range(0, 3))
      0: return KEY_W'($urandom());
      1: begin
        base = pick_known_key();
        return base + 1'b1;
      end
      2: begin
        base = pick_known_key();
        return base - 1'b1;
      end
      default: return $urandom_range(0, 1) ? KEY_W'($urandom_range(0, 15))
                                           : ~KEY_W'($urandom_range(0, 15));
    endcase
  endfunction

  // offer one word and hold it until taken; an optional idle burst goes first
  task automatic send_doc(input logic [DOC_W-1:0] doc);
    logic [KEY_W-1:0] key;
    if (!calm_tail && $urandom_range(0, 99) < tx_gap_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    doc_id_i   <= doc;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    key = doc[DOC_W-1:DOC_W-KEY_W];
    if (!key_seen.exists(key) && key_pool.size() < CAPACITY) begin
      key_seen[key] = 1'b1;
      key_pool.insert(key_pool.size(), key);
    end
  endtask

  // low half of the doc id is don't-care for the lookup, so keep it random
  task automatic send_key(input logic [KEY_W-1:0] key);
    send_doc({key, 32'($urandom())});
  endtask

  // output side: random stall bursts, plus one long hold-off on request so
  // the block backs up and stalls its input while words keep coming
  initial begin
    int cyc;
    cyc          = 0;
    out_stall_i  = 1'b0;
    rx_stall_pct = 0;
    holds_done   = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 128 == 0) rx_stall_pct = pick_idle_pct();
      if (long_hold_req) begin
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        out_stall_i   <= 1'b0;
        long_hold_req = 1'b0;
        holds_done++;
      end else if (!calm_tail && $urandom_range(0, 99) < rx_stall_pct) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog: cycles in a row with no word moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
      if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no word moved for %0d cycles, %0d results outstanding",
                 stuck_cycles, pending);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    doc_id_i      = '0;
    tx_gap_pct    = 0;
    calm_tail     = 1'b0;
    long_hold_req = 1'b0;
    words_sent    = 0;
    stuck_cycles  = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed opener: first insert into an empty table, hits with other low
    // bits, inserts at head, tail and middle, all-zero and all-ones doc ids
    send_doc(64'h8000_0000_0000_0000);  // empty table, first handle
    send_doc(64'h8000_0000_FFFF_FFFF);  // same key, other low half: hit
    send_doc(64'h0000_0000_FFFF_FFFF);  // smallest key goes to the head
    send_doc(64'hFFFF_FFFF_0000_0000);  // largest key goes to the tail
    send_doc(64'h7FFF_FFFF_1234_5678);  // middle, just below the first key
    send_doc(64'h8000_0001_0000_0001);  // middle, just above it
    send_doc(64'h0000_0001_8000_0000);  // one behind the head
    send_doc(64'hFFFF_FFFE_7FFF_FFFF);  // one before the tail
    send_doc(64'h0000_0000_0000_0000);  // all zero: hit on the head
    send_doc(64'hFFFF_FFFF_FFFF_FFFF);  // all ones: hit on the tail
    send_doc(64'h5555_5555_AAAA_AAAA);
    send_doc(64'hAAAA_AAAA_5555_5555);
    send_doc(64'h7FFF_FFFF_0000_0000);  // hit in the middle
    send_doc(64'h8000_0000_8000_0000);  // hit on the very first entry
    send_doc(64'h0000_0002_0000_0000);
    send_doc(64'hFFFF_FFFD_0000_0000);
    send_doc(64'h5555_5554_0000_0000);  // neighbors on both sides of a stored key
    send_doc(64'h5555_5556_0000_0000);
    send_doc(64'hAAAA_AAAA_0000_0000);
    send_doc(64'h0000_0001_0000_0000);

    // random part: fill the table with a mix of new keys and hits, then keep
    // hitting stored keys while absent ones get refused as full
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i % 64 == 0) tx_gap_pct = pick_idle_pct();
      if (i == RANDOM_WORDS - CALM_WORDS) calm_tail = 1'b1;
      if (i == HOLD_AT_WORD) begin
        tx_gap_pct    = 0;  // keep offering so the block fills up behind the hold-off
        long_hold_req = 1'b1;
      end
      if ($urandom_range(0, 19) == 0)
        send_doc({$urandom(), $urandom()});
      else if (key_pool.size() < CAPACITY)
        send_key($urandom_range(0, 99) < 40 ? pick_fresh_key() : pick_known_key());
      else
        send_key($urandom_range(0, 99) < 70 ? pick_known_key() : pick_fresh_key());
    end
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d words: %0d keys inserted, %0d lookups hit, %0d refused on a full table",
             words_sent, n_inserted, n_hit, n_refused);
    $display("output held off for %0d cycles %0d time(s); idle bursts on both sides",
             LONG_HOLD, holds_done);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
